// ----- src/toml_string_literal_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// toml string literal decoder assertion macros
// concurrent checks on clk, disabled while rst_n is low; empty in synthesis
// ----------------------------------------------------------------------------
`ifndef TOML_STRING_LITERAL_DECODER_ASSERT_SVH
`define TOML_STRING_LITERAL_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define TSLD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tsld assertion failed");
// condition must never be true at a clock edge out of reset
`define TSLD_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tsld forbidden condition seen");
`else
`define TSLD_ASSERT(label, prop)
`define TSLD_NEVER(label, cond)
`endif
`endif

// ----- src/tsld_pkg.sv -----
// ----------------------------------------------------------------------------
// tsld_pkg
// shared codes and the result record passed from parser to serializer
// ----------------------------------------------------------------------------
package tsld_pkg;

    // result status
    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_DELIM = 3'd1;
    localparam logic [2:0] ERR_EARLY    = 3'd2;
    localparam logic [2:0] ERR_CTRL     = 3'd3;
    localparam logic [2:0] ERR_BAD_ESC  = 3'd4;
    localparam logic [2:0] ERR_BAD_HEX  = 3'd5;
    localparam logic [2:0] ERR_BAD_CP   = 3'd6;
    localparam logic [2:0] ERR_LONG_RUN = 3'd7;

    // string kinds
    localparam logic [1:0] KIND_BASIC      = 2'd0;
    localparam logic [1:0] KIND_LITERAL    = 2'd1;
    localparam logic [1:0] KIND_ML_BASIC   = 2'd2;
    localparam logic [1:0] KIND_ML_LITERAL = 2'd3;

    // record queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // up to four data bytes followed by an optional terminal result
    typedef struct packed {
        logic [2:0]      n_data;
        logic [3:0][7:0] data;
        logic            term;
        logic [1:0]      status;
        logic [2:0]      err;
        logic            unused;
        logic [1:0]      kind;
    } rec_t;

endpackage

// ----- src/tsld_front.sv -----
// ----------------------------------------------------------------------------
// tsld_front
// per-byte string parser: updates parse state and builds one result record
// ----------------------------------------------------------------------------
`include "toml_string_literal_decoder_assert.svh"

module tsld_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             end_of_input,
    output tsld_pkg::rec_t   rec,
    output logic             has_result
);

    localparam logic [3:0] M_IDLE   = 4'd0;
    localparam logic [3:0] M_DQ1    = 4'd1;
    localparam logic [3:0] M_DQ2    = 4'd2;
    localparam logic [3:0] M_SQ1    = 4'd3;
    localparam logic [3:0] M_SQ2    = 4'd4;
    localparam logic [3:0] M_SINGLE = 4'd5;
    localparam logic [3:0] M_MULTI  = 4'd6;
    localparam logic [3:0] M_ESC    = 4'd7;
    localparam logic [3:0] M_HEX    = 4'd8;
    localparam logic [3:0] M_ESCWS  = 4'd9;
    localparam logic [3:0] M_TRIM   = 4'd10;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    logic [3:0]  mode_reg, mode_next;
    logic [2:0]  qrun_reg, qrun_next;
    logic [20:0] hexv_reg, hexv_next;
    logic        hexovf_reg, hexovf_next;
    logic [3:0]  hexleft_reg, hexleft_next;
    logic        swallow_reg, swallow_next;
    logic        acs_reg, acs_next;
    logic [1:0]  kind_reg, kind_next;

    // bit 4 set when not a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        if (c >= 8'h30 && c <= 8'h39)
            d = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            d = {1'b0, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            d = {1'b0, 4'(c - 8'h37)};
        else
            d = 5'h10;
        return d;
    endfunction

    always_comb
    begin
        logic [7:0]  q;
        logic        is_ctrl;
        logic        is_blank;
        logic        is_nl;
        logic        do_single;
        logic        do_multi;
        logic        ms_sw;
        logic        skip;
        logic        finish;
        logic [4:0]  hd;
        logic [20:0] hv;
        logic        hovf;
        logic        cp_bad;
        logic [2:0]  nq;
        logic [3:0]  back_mode;
        logic        esc_hit;
        logic [7:0]  esc_val;

        mode_next    = mode_reg;
        qrun_next    = qrun_reg;
        hexv_next    = hexv_reg;
        hexovf_next  = hexovf_reg;
        hexleft_next = hexleft_reg;
        swallow_next = swallow_reg;
        acs_next     = acs_reg;
        kind_next    = kind_reg;
        rec          = '0;

        q         = (kind_reg == tsld_pkg::KIND_ML_BASIC) ? CH_DQUOTE : CH_SQUOTE;
        is_ctrl   = (in_byte <= 8'h08) || (in_byte >= 8'h0A && in_byte <= 8'h1F)
                    || (in_byte == 8'h7F);
        is_blank  = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
        is_nl     = (in_byte == CH_LF) || (in_byte == CH_CR);
        do_single = 1'b0;
        do_multi  = 1'b0;
        ms_sw     = swallow_reg;
        skip      = 1'b0;
        finish    = 1'b0;
        hd        = hex_digit(in_byte);
        hv        = {hexv_reg[16:0], hd[3:0]};
        hovf      = hexovf_reg || (hexv_reg[20:17] != 4'd0);
        cp_bad    = hovf || (hv > 21'h10FFFF) || (hv >= 21'h00D800 && hv <= 21'h00DFFF);
        nq        = qrun_reg + 3'd1;
        back_mode = (kind_reg == tsld_pkg::KIND_ML_BASIC) ? M_MULTI : M_SINGLE;
        esc_hit   = 1'b0;
        esc_val   = 8'h00;

        if (end_of_input)
        begin
            finish   = 1'b1;
            rec.term = 1'b1;
            unique case (mode_reg)
                M_IDLE:
                begin
                    kind_next  = tsld_pkg::KIND_BASIC;
                    rec.status = tsld_pkg::ST_ERROR;
                    rec.err    = tsld_pkg::ERR_NO_DELIM;
                end
                M_DQ2, M_SQ2:
                begin
                    rec.status = tsld_pkg::ST_DONE;
                end
                M_MULTI:
                begin
                    if (qrun_reg >= 3'd3)
                    begin
                        rec.data[0] = q;
                        rec.data[1] = q;
                        rec.n_data  = qrun_reg - 3'd3;
                        rec.status  = tsld_pkg::ST_DONE;
                    end
                    else
                    begin
                        rec.status = tsld_pkg::ST_ERROR;
                        rec.err    = tsld_pkg::ERR_EARLY;
                    end
                end
                default:
                begin
                    rec.status = tsld_pkg::ST_ERROR;
                    rec.err    = tsld_pkg::ERR_EARLY;
                end
            endcase
        end
        else
        begin
            unique case (mode_reg)
                M_IDLE:
                begin
                    if (in_byte == CH_DQUOTE)
                    begin
                        kind_next = tsld_pkg::KIND_BASIC;
                        mode_next = M_DQ1;
                    end
                    else if (in_byte == CH_SQUOTE)
                    begin
                        kind_next = tsld_pkg::KIND_LITERAL;
                        mode_next = M_SQ1;
                    end
                    else
                    begin
                        kind_next  = tsld_pkg::KIND_BASIC;
                        finish     = 1'b1;
                        rec.term   = 1'b1;
                        rec.status = tsld_pkg::ST_ERROR;
                        rec.err    = tsld_pkg::ERR_NO_DELIM;
                        rec.unused = 1'b1;
                    end
                end
                M_DQ1, M_SQ1:
                begin
                    if (in_byte == ((mode_reg == M_DQ1) ? CH_DQUOTE : CH_SQUOTE))
                        mode_next = (mode_reg == M_DQ1) ? M_DQ2 : M_SQ2;
                    else
                    begin
                        mode_next = M_SINGLE;
                        do_single = 1'b1;
                    end
                end
                M_DQ2, M_SQ2:
                begin
                    if (in_byte == ((mode_reg == M_DQ2) ? CH_DQUOTE : CH_SQUOTE))
                    begin
                        kind_next    = (mode_reg == M_DQ2) ? tsld_pkg::KIND_ML_BASIC
                                                           : tsld_pkg::KIND_ML_LITERAL;
                        mode_next    = M_MULTI;
                        qrun_next    = 3'd0;
                        swallow_next = 1'b0;
                        acs_next     = 1'b1;
                    end
                    else
                    begin
                        // empty string, closing decided by this byte
                        finish     = 1'b1;
                        rec.term   = 1'b1;
                        rec.status = tsld_pkg::ST_DONE;
                        rec.unused = 1'b1;
                    end
                end
                M_SINGLE:
                begin
                    do_single = 1'b1;
                end
                M_MULTI:
                begin
                    do_multi = 1'b1;
                end
                M_ESC:
                begin
                    unique case (in_byte)
                        8'h62: begin esc_hit = 1'b1; esc_val = 8'h08; end
                        8'h74: begin esc_hit = 1'b1; esc_val = 8'h09; end
                        8'h6E: begin esc_hit = 1'b1; esc_val = 8'h0A; end
                        8'h66: begin esc_hit = 1'b1; esc_val = 8'h0C; end
                        8'h72: begin esc_hit = 1'b1; esc_val = 8'h0D; end
                        CH_DQUOTE: begin esc_hit = 1'b1; esc_val = CH_DQUOTE; end
                        CH_BSLASH: begin esc_hit = 1'b1; esc_val = CH_BSLASH; end
                        8'h75:
                        begin
                            hexleft_next = 4'd4;
                            hexv_next    = '0;
                            hexovf_next  = 1'b0;
                            mode_next    = M_HEX;
                        end
                        8'h55:
                        begin
                            hexleft_next = 4'd8;
                            hexv_next    = '0;
                            hexovf_next  = 1'b0;
                            mode_next    = M_HEX;
                        end
                        default:
                        begin
                            if (kind_reg == tsld_pkg::KIND_ML_BASIC && is_blank)
                                mode_next = M_ESCWS;
                            else if (kind_reg == tsld_pkg::KIND_ML_BASIC && is_nl)
                                mode_next = M_TRIM;
                            else
                            begin
                                finish     = 1'b1;
                                rec.term   = 1'b1;
                                rec.status = tsld_pkg::ST_ERROR;
                                rec.err    = tsld_pkg::ERR_BAD_ESC;
                            end
                        end
                    endcase
                    if (esc_hit)
                    begin
                        rec.data[0] = esc_val;
                        rec.n_data  = 3'd1;
                        mode_next   = back_mode;
                    end
                end
                M_HEX:
                begin
                    if (hd[4])
                    begin
                        finish     = 1'b1;
                        rec.term   = 1'b1;
                        rec.status = tsld_pkg::ST_ERROR;
                        rec.err    = tsld_pkg::ERR_BAD_HEX;
                    end
                    else
                    begin
                        hexleft_next = hexleft_reg - 4'd1;
                        if (hexleft_reg != 4'd1)
                        begin
                            hexv_next   = hv;
                            hexovf_next = hovf;
                        end
                        else
                        begin
                            hexv_next   = '0;
                            hexovf_next = 1'b0;
                            if (cp_bad)
                            begin
                                finish     = 1'b1;
                                rec.term   = 1'b1;
                                rec.status = tsld_pkg::ST_ERROR;
                                rec.err    = tsld_pkg::ERR_BAD_CP;
                            end
                            else
                            begin
                                mode_next = back_mode;
                                // utf-8 encoding of the code point
                                if (hv < 21'h000080)
                                begin
                                    rec.data[0] = hv[7:0];
                                    rec.n_data  = 3'd1;
                                end
                                else if (hv < 21'h000800)
                                begin
                                    rec.data[0] = {3'b110, hv[10:6]};
                                    rec.data[1] = {2'b10, hv[5:0]};
                                    rec.n_data  = 3'd2;
                                end
                                else if (hv < 21'h010000)
                                begin
                                    rec.data[0] = {4'b1110, hv[15:12]};
                                    rec.data[1] = {2'b10, hv[11:6]};
                                    rec.data[2] = {2'b10, hv[5:0]};
                                    rec.n_data  = 3'd3;
                                end
                                else
                                begin
                                    rec.data[0] = {5'b11110, hv[20:18]};
                                    rec.data[1] = {2'b10, hv[17:12]};
                                    rec.data[2] = {2'b10, hv[11:6]};
                                    rec.data[3] = {2'b10, hv[5:0]};
                                    rec.n_data  = 3'd4;
                                end
                            end
                        end
                    end
                end
                M_ESCWS:
                begin
                    if (is_nl)
                        mode_next = M_TRIM;
                    else if (!is_blank)
                    begin
                        finish     = 1'b1;
                        rec.term   = 1'b1;
                        rec.status = tsld_pkg::ST_ERROR;
                        rec.err    = tsld_pkg::ERR_BAD_ESC;
                    end
                end
                M_TRIM:
                begin
                    if (!is_blank && !is_nl)
                    begin
                        mode_next    = M_MULTI;
                        swallow_next = 1'b0;
                        ms_sw        = 1'b0;
                        do_multi     = 1'b1;
                    end
                end
                default:
                begin
                    finish = 1'b1;
                end
            endcase

            // single-line body byte
            if (do_single)
            begin
                if (in_byte == ((kind_reg == tsld_pkg::KIND_BASIC) ? CH_DQUOTE : CH_SQUOTE))
                begin
                    finish     = 1'b1;
                    rec.term   = 1'b1;
                    rec.status = tsld_pkg::ST_DONE;
                end
                else if (is_ctrl)
                begin
                    finish     = 1'b1;
                    rec.term   = 1'b1;
                    rec.status = tsld_pkg::ST_ERROR;
                    rec.err    = tsld_pkg::ERR_CTRL;
                end
                else if (kind_reg == tsld_pkg::KIND_BASIC && in_byte == CH_BSLASH)
                    mode_next = M_ESC;
                else
                begin
                    rec.data[0] = in_byte;
                    rec.n_data  = 3'd1;
                end
            end

            // multiline body byte with newline folding and quote runs
            if (do_multi)
            begin
                if (ms_sw)
                begin
                    swallow_next = 1'b0;
                    if (in_byte == CH_LF)
                        skip = 1'b1;
                end
                if (!skip && acs_reg)
                begin
                    acs_next = 1'b0;
                    if (in_byte == CH_LF)
                        skip = 1'b1;
                    else if (in_byte == CH_CR)
                    begin
                        swallow_next = 1'b1;
                        skip         = 1'b1;
                    end
                end
                if (!skip)
                begin
                    if (in_byte == q)
                    begin
                        qrun_next = nq;
                        if (nq >= 3'd6)
                        begin
                            finish     = 1'b1;
                            rec.term   = 1'b1;
                            rec.status = tsld_pkg::ST_ERROR;
                            rec.err    = tsld_pkg::ERR_LONG_RUN;
                        end
                    end
                    else if (qrun_reg >= 3'd3)
                    begin
                        // closing run: extra quotes are content
                        rec.data[0] = q;
                        rec.data[1] = q;
                        rec.n_data  = qrun_reg - 3'd3;
                        finish      = 1'b1;
                        rec.term    = 1'b1;
                        rec.status  = tsld_pkg::ST_DONE;
                        rec.unused  = 1'b1;
                    end
                    else
                    begin
                        rec.data[0] = q;
                        rec.data[1] = q;
                        rec.n_data  = qrun_reg;
                        qrun_next   = 3'd0;
                        if (is_nl)
                        begin
                            rec.data[qrun_reg[1:0]] = CH_LF;
                            rec.n_data              = qrun_reg + 3'd1;
                            if (in_byte == CH_CR)
                                swallow_next = 1'b1;
                        end
                        else if (is_ctrl)
                        begin
                            finish     = 1'b1;
                            rec.term   = 1'b1;
                            rec.status = tsld_pkg::ST_ERROR;
                            rec.err    = tsld_pkg::ERR_CTRL;
                        end
                        else if (kind_reg == tsld_pkg::KIND_ML_BASIC && in_byte == CH_BSLASH)
                            mode_next = M_ESC;
                        else
                        begin
                            rec.data[qrun_reg[1:0]] = in_byte;
                            rec.n_data              = qrun_reg + 3'd1;
                        end
                    end
                end
            end
        end

        if (finish)
        begin
            mode_next    = M_IDLE;
            qrun_next    = 3'd0;
            hexv_next    = '0;
            hexovf_next  = 1'b0;
            hexleft_next = 4'd0;
            swallow_next = 1'b0;
            acs_next     = 1'b0;
        end
        rec.kind = kind_next;
    end

    assign has_result = (rec.n_data != 3'd0) || rec.term;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= M_IDLE;
            qrun_reg    <= 3'd0;
            hexv_reg    <= '0;
            hexovf_reg  <= 1'b0;
            hexleft_reg <= 4'd0;
            swallow_reg <= 1'b0;
            acs_reg     <= 1'b0;
            kind_reg    <= tsld_pkg::KIND_BASIC;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            qrun_reg    <= qrun_next;
            hexv_reg    <= hexv_next;
            hexovf_reg  <= hexovf_next;
            hexleft_reg <= hexleft_next;
            swallow_reg <= swallow_next;
            acs_reg     <= acs_next;
            kind_reg    <= kind_next;
        end
    end

    `TSLD_ASSERT(a_hex_left_live, (mode_reg == M_HEX) |-> (hexleft_reg != 4'd0))
    `TSLD_NEVER(a_qrun_outside_multi, (mode_reg != M_MULTI) && (qrun_reg != 3'd0))

endmodule

// ----- src/tsld_fifo.sv -----
// ----------------------------------------------------------------------------
// tsld_fifo
// short record queue between parser and serializer
// ----------------------------------------------------------------------------
`include "toml_string_literal_decoder_assert.svh"

module tsld_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tsld_pkg::rec_t wr_rec,
    input  logic           pop,
    output tsld_pkg::rec_t head,
    output logic           full,
    output logic           empty
);

    tsld_pkg::rec_t                      mem_reg [tsld_pkg::FIFO_DEPTH];
    logic [tsld_pkg::FIFO_AW-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [tsld_pkg::FIFO_CW-1:0]        count_reg;

    function automatic logic [tsld_pkg::FIFO_AW-1:0] ptr_inc(
        input logic [tsld_pkg::FIFO_AW-1:0] p);
        logic [tsld_pkg::FIFO_AW-1:0] r;
        if (p == tsld_pkg::FIFO_AW'(tsld_pkg::FIFO_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    assign full  = (count_reg == tsld_pkg::FIFO_CW'(tsld_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    `TSLD_NEVER(a_push_when_full, push && full)

endmodule

// ----- src/tsld_back.sv -----
// ----------------------------------------------------------------------------
// tsld_back
// serializer: walks one record and presents its results one beat at a time
// ----------------------------------------------------------------------------
`include "toml_string_literal_decoder_assert.svh"

module tsld_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  tsld_pkg::rec_t head,
    input  logic           head_valid,
    input  logic           out_stall,
    output logic           pop,
    output logic [7:0]     out_byte,
    output logic [1:0]     status,
    output logic [2:0]     error_code,
    output logic [1:0]     string_kind,
    output logic           byte_unused,
    output logic           last
);

    logic [2:0] idx_reg, idx_next;
    logic [2:0] total;
    logic       is_data;
    logic       take;

    assign total   = head.n_data + {2'b00, head.term};
    assign is_data = (idx_reg < head.n_data);
    assign last    = (idx_reg == total - 3'd1);
    assign take    = head_valid && !out_stall;
    assign pop     = take && last;

    assign out_byte    = is_data ? head.data[idx_reg[1:0]] : 8'h00;
    assign status      = is_data ? tsld_pkg::ST_DATA : head.status;
    assign error_code  = is_data ? tsld_pkg::ERR_NONE : head.err;
    assign byte_unused = is_data ? 1'b0 : head.unused;
    assign string_kind = head.kind;

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
            idx_next = last ? 3'd0 : idx_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 3'd0;
        else
            idx_reg <= idx_next;
    end

    `TSLD_NEVER(a_idx_in_record, head_valid && (idx_reg >= total))
    `TSLD_ASSERT(a_record_held, (head_valid && !out_stall && !last) |=> head_valid)

endmodule

// ----- src/toml_string_literal_decoder.sv -----
// ----------------------------------------------------------------------------
// toml_string_literal_decoder
// decodes one toml string token per call into content bytes plus a status
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_stall  | in_byte, end_of_input
//  out     | out_valid/out_stall| out_byte, status, error_code, string_kind,
//          |                    | byte_unused, last
//
//  an input beat is parsed in the cycle it is accepted; one beat per cycle while in_stall is low
//  an item giving k results holds the output for k beats (k from 1 to 4)
//  a 4-entry record queue sits between parser and serializer; in_stall is
//  raised only while that queue is full
//  reset puts the parser in idle awaiting a delimiter and empties the queue;
//  no clearing pass, inputs are taken right after reset
//
// front: tsld_front parses a beat and builds a record of up to four data
// bytes plus an optional finish or error result
// queue: tsld_fifo holds records so the parser keeps going while the
// consumer stalls
// back: tsld_back walks the head record one result beat at a time and
// marks the final result of the item with last
// ----------------------------------------------------------------------------
module toml_string_literal_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [1:0] status,
    output logic [2:0] error_code,
    output logic [1:0] string_kind,
    output logic       byte_unused,
    output logic       last
);

    tsld_pkg::rec_t rec;
    tsld_pkg::rec_t head;
    logic           has_result;
    logic           accept;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;

    // input beat taken whenever the queue has room
    assign in_stall = full;
    assign accept   = in_valid && !in_stall;
    // items that leave no result (prefix bytes, escapes in flight) push nothing
    assign push     = accept && has_result;
    assign out_valid = !empty;

    tsld_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .rec          (rec),
        .has_result   (has_result)
    );

    tsld_fifo u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_rec (rec),
        .pop    (pop),
        .head   (head),
        .full   (full),
        .empty  (empty)
    );

    tsld_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (out_valid),
        .out_stall   (out_stall),
        .pop         (pop),
        .out_byte    (out_byte),
        .status      (status),
        .error_code  (error_code),
        .string_kind (string_kind),
        .byte_unused (byte_unused),
        .last        (last)
    );

endmodule

// ----- dv/toml_string_literal_decoder_test.sv -----
// ----------------------------------------------------------------------------
// toml_string_literal_decoder_test
// self-checking bench for the toml string decoder: streams string tokens,
// noise and end-of-input marks through the in channel and checks every out
// beat against a cycle-free decoder kept in a small scoreboard class
// ----------------------------------------------------------------------------
module toml_string_literal_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 3;
    localparam int RAND_ITEMS  = 420;
    localparam int DRAIN       = 32;
    localparam int CYCLE_LIMIT = 200000;

    // characters the decoder treats specially
    localparam bit [7:0] CH_DQ  = 8'h22;
    localparam bit [7:0] CH_SQ  = 8'h27;
    localparam bit [7:0] CH_BSL = 8'h5C;
    localparam bit [7:0] CH_SP  = 8'h20;
    localparam bit [7:0] CH_TAB = 8'h09;
    localparam bit [7:0] CH_LF  = 8'h0A;
    localparam bit [7:0] CH_CR  = 8'h0D;

    // parser position within a token
    typedef enum logic [3:0] {
        PM_IDLE, PM_DQ1, PM_DQ2, PM_SQ1, PM_SQ2, PM_SINGLE, PM_MULTI,
        PM_ESC, PM_HEX, PM_ESCWS, PM_TRIM
    } pmode_t;

    // one out beat
    typedef struct {
        bit [7:0]   data;
        logic [1:0] status;
        logic [2:0] err;
        logic [1:0] kind;
        bit         unused;
        bit         last;
    } result_t;

    // one in beat
    typedef struct {
        bit [7:0] b;
        bit       eoi;
    } stim_t;

    // ------------------------------------------------------------------------
    // scoreboard: decodes each accepted in beat and checks the out beats
    // ------------------------------------------------------------------------
    class decode_scoreboard;
        result_t     decoded_q[$];
        result_t     step_q[$];
        pmode_t      mode;
        int unsigned qrun;
        bit [31:0]   hexacc;
        int unsigned hexcnt;
        bit          drop_lf;
        bit          fresh;
        logic [1:0]  kind;
        int unsigned mismatches;
        int unsigned n_beats, n_data, n_done, n_err;

        function new();
            go_idle();
            kind = tsld_pkg::KIND_BASIC;
        endfunction

        function int unsigned pending();
            return decoded_q.size();
        endfunction

        task report(string msg);
            if (mismatches < 40)
                $display("%0t mismatch: %s", $time, msg);
            mismatches++;
        endtask

        function void go_idle();
            mode    = PM_IDLE;
            qrun    = 0;
            hexacc  = '0;
            hexcnt  = 0;
            drop_lf = 1'b0;
            fresh   = 1'b0;
        endfunction

        function void put(bit [7:0] b, logic [1:0] st, logic [2:0] er, bit un);
            result_t r;
            if (step_q.size() >= 4)
                return;
            r.data   = b;
            r.status = st;
            r.err    = er;
            r.kind   = kind;
            r.unused = un;
            r.last   = 1'b0;
            step_q.push_back(r);
        endfunction

        function void close_out(logic [1:0] st, logic [2:0] er, bit un);
            put(8'h00, st, er, un);
            go_idle();
        endfunction

        function bit is_ctrl(bit [7:0] c);
            return c <= 8'h08 || (c >= 8'h0A && c <= 8'h1F) || c == 8'h7F;
        endfunction

        function int hex_nibble(bit [7:0] c);
            if (c >= "0" && c <= "9") return int'(c - "0");
            if (c >= "a" && c <= "f") return int'(c - "a") + 10;
            if (c >= "A" && c <= "F") return int'(c - "A") + 10;
            return 16;
        endfunction

        function bit [7:0] ml_quote();
            return kind == tsld_pkg::KIND_ML_BASIC ? CH_DQ : CH_SQ;
        endfunction

        function pmode_t body_mode();
            return kind == tsld_pkg::KIND_ML_BASIC ? PM_MULTI : PM_SINGLE;
        endfunction

        function void single_line(bit [7:0] c);
            bit [7:0] close_c;
            close_c = kind == tsld_pkg::KIND_BASIC ? CH_DQ : CH_SQ;
            if (c == close_c)
                close_out(tsld_pkg::ST_DONE, tsld_pkg::ERR_NONE, 1'b0);
            else if (is_ctrl(c))
                close_out(tsld_pkg::ST_ERROR, tsld_pkg::ERR_CTRL, 1'b0);
            else if (kind == tsld_pkg::KIND_BASIC && c == CH_BSL)
                mode = PM_ESC;
            else
                put(c, tsld_pkg::ST_DATA, tsld_pkg::ERR_NONE, 1'b0);
        endfunction

        function void ml_body(bit [7:0] c);
            if (c == CH_LF)
            begin
                put(CH_LF, tsld_pkg::ST_DATA, tsld_pkg::ERR_NONE, 1'b0);
            end
            else if (c == CH_CR)
            begin
                put(CH_LF, tsld_pkg::ST_DATA, tsld_pkg::ERR_NONE, 1'b0);
                drop_lf = 1'b1;
            end
            else if (is_ctrl(c))
            begin
                close_out(tsld_pkg::ST_ERROR, tsld_pkg::ERR_CTRL, 1'b0);
            end
            else if (kind == tsld_pkg::KIND_ML_BASIC && c == CH_BSL)
            begin
                mode = PM_ESC;
            end
            else
            begin
                put(c, tsld_pkg::ST_DATA, tsld_pkg::ERR_NONE, 1'b0);
            end
        endfunction

        // a closing run of 4 or 5 keeps its extra quotes as content
        function void ml_close(bit un);
            for (int unsigned i = 3; i < qrun; i++)
                put(ml_quote(), tsld_pkg::ST_DATA, tsld_pkg::ERR_NONE, 1'b0);
            close_out(tsld_pkg::ST_DONE, tsld_pkg::ERR_NONE, un);
        endfunction

        function void ml_byte(bit [7:0] c);
            if (drop_lf)
            begin
                drop_lf = 1'b0;
                if (c == CH_LF)
                    return;
            end
            if (fresh)
            begin
                fresh = 1'b0;
                if (c == CH_LF)
                    return;
                if (c == CH_CR)
                begin
                    drop_lf = 1'b1;
                    return;
                end
            end
            if (c == ml_quote())
            begin
                qrun++;
                if (qrun >= 6)
                    close_out(tsld_pkg::ST_ERROR, tsld_pkg::ERR_LONG_RUN, 1'b0);
                return;
            end
            if (qrun >= 3)
            begin
                ml_close(1'b1);
                return;
            end
            repeat (qrun) put(ml_quote(), tsld_pkg::ST_DATA, tsld_pkg::ERR_NONE, 1'b0);
            qrun = 0;
            ml_body(c);
        endfunction

        function void escape(bit [7:0] c);
            bit [7:0] v;
            bit       hit;
            hit = 1'b1;
            v   = 8'h00;
            case (c)
                "b":    v = 8'h08;
                "t":    v = 8'h09;
                "n":    v = 8'h0A;
                "f":    v = 8'h0C;
                "r":    v = 8'h0D;
                CH_DQ:  v = CH_DQ;
                CH_BSL: v = CH_BSL;
                "u":
                begin
                    hit    = 1'b0;
                    hexcnt = 4;
                    hexacc = '0;
                    mode   = PM_HEX;
                end
                "U":
                begin
                    hit    = 1'b0;
                    hexcnt = 8;
                    hexacc = '0;
                    mode   = PM_HEX;
                end
                default:
                begin
                    hit = 1'b0;
                    if (kind == tsld_pkg::KIND_ML_BASIC && (c == CH_SP || c == CH_TAB))
                        mode = PM_ESCWS;
                    else if (kind == tsld_pkg::KIND_ML_BASIC && (c == CH_LF || c == CH_CR))
                        mode = PM_TRIM;
                    else
                        close_out(tsld_pkg::ST_ERROR, tsld_pkg::ERR_BAD_ESC, 1'b0);
                end
            endcase
            if (hit)
            begin
                put(v, tsld_pkg::ST_DATA, tsld_pkg::ERR_NONE, 1'b0);
                mode = body_mode();
            end
        endfunction

        function void hex_digit_in(bit [7:0] c);
            int        d;
            bit [31:0] cp;
            d = hex_nibble(c);
            if (d > 15)
            begin
                close_out(tsld_pkg::ST_ERROR, tsld_pkg::ERR_BAD_HEX, 1'b0);
                return;
            end
            hexacc = {hexacc[27:0], 4'(d)};
            if (hexcnt > 0)
                hexcnt--;
            if (hexcnt != 0)
                return;
            cp     = hexacc;
            hexacc = '0;
            if (cp > 32'h10FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF))
            begin
                close_out(tsld_pkg::ST_ERROR, tsld_pkg::ERR_BAD_CP, 1'b0);
                return;
            end
            // utf-8 encoding of the code point
            if (cp < 32'h80)
            begin
                put(8'(cp), tsld_pkg::ST_DATA, tsld_pkg::ERR_NONE, 1'b0);
            end
            else if (cp < 32'h800)
            begin
                put(8'hC0 | 8'(cp >> 6), tsld_pkg::ST_DATA, tsld_pkg::ERR_NONE, 1'b0);
                put(8'h80 | 8'(cp & 32'h3F), tsld_pkg::ST_DATA, tsld_pkg::ERR_NONE, 1'b0);
            end
            else if (cp < 32'h10000)
            begin
                put(8'hE0 | 8'(cp >> 12), tsld_pkg::ST_DATA, tsld_pkg::ERR_NONE, 1'b0);
                put(8'h80 | 8'((cp >> 6) & 32'h3F), tsld_pkg::ST_DATA,
                    tsld_pkg::ERR_NONE, 1'b0);
                put(8'h80 | 8'(cp & 32'h3F), tsld_pkg::ST_DATA, tsld_pkg::ERR_NONE, 1'b0);
            end
            else
            begin
                put(8'hF0 | 8'(cp >> 18), tsld_pkg::ST_DATA, tsld_pkg::ERR_NONE, 1'b0);
                put(8'h80 | 8'((cp >> 12) & 32'h3F), tsld_pkg::ST_DATA,
                    tsld_pkg::ERR_NONE, 1'b0);
                put(8'h80 | 8'((cp >> 6) & 32'h3F), tsld_pkg::ST_DATA,
                    tsld_pkg::ERR_NONE, 1'b0);
                put(8'h80 | 8'(cp & 32'h3F), tsld_pkg::ST_DATA, tsld_pkg::ERR_NONE, 1'b0);
            end
            mode = body_mode();
        endfunction

        function void end_mark();
            case (mode)
                PM_IDLE:
                begin
                    kind = tsld_pkg::KIND_BASIC;
                    close_out(tsld_pkg::ST_ERROR, tsld_pkg::ERR_NO_DELIM, 1'b0);
                end
                PM_DQ2, PM_SQ2: close_out(tsld_pkg::ST_DONE, tsld_pkg::ERR_NONE, 1'b0);
                PM_MULTI:
                begin
                    if (qrun >= 3)
                        ml_close(1'b0);
                    else
                        close_out(tsld_pkg::ST_ERROR, tsld_pkg::ERR_EARLY, 1'b0);
                end
                default: close_out(tsld_pkg::ST_ERROR, tsld_pkg::ERR_EARLY, 1'b0);
            endcase
        endfunction

        function void text_byte(bit [7:0] c);
            case (mode)
                PM_IDLE:
                begin
                    if (c == CH_DQ)
                    begin
                        kind = tsld_pkg::KIND_BASIC;
                        mode = PM_DQ1;
                    end
                    else if (c == CH_SQ)
                    begin
                        kind = tsld_pkg::KIND_LITERAL;
                        mode = PM_SQ1;
                    end
                    else
                    begin
                        kind = tsld_pkg::KIND_BASIC;
                        close_out(tsld_pkg::ST_ERROR, tsld_pkg::ERR_NO_DELIM, 1'b1);
                    end
                end
                PM_DQ1, PM_SQ1:
                begin
                    if (c == (mode == PM_DQ1 ? CH_DQ : CH_SQ))
                    begin
                        mode = (mode == PM_DQ1) ? PM_DQ2 : PM_SQ2;
                    end
                    else
                    begin
                        mode = PM_SINGLE;
                        single_line(c);
                    end
                end
                PM_DQ2, PM_SQ2:
                begin
                    // third quote opens a multiline form, anything else is ""
                    if (c == (mode == PM_DQ2 ? CH_DQ : CH_SQ))
                    begin
                        kind    = (mode == PM_DQ2) ? tsld_pkg::KIND_ML_BASIC
                                                   : tsld_pkg::KIND_ML_LITERAL;
                        mode    = PM_MULTI;
                        qrun    = 0;
                        drop_lf = 1'b0;
                        fresh   = 1'b1;
                    end
                    else
                    begin
                        close_out(tsld_pkg::ST_DONE, tsld_pkg::ERR_NONE, 1'b1);
                    end
                end
                PM_SINGLE: single_line(c);
                PM_MULTI:  ml_byte(c);
                PM_ESC:    escape(c);
                PM_HEX:    hex_digit_in(c);
                PM_ESCWS:
                begin
                    if (c == CH_LF || c == CH_CR)
                        mode = PM_TRIM;
                    else if (c != CH_SP && c != CH_TAB)
                        close_out(tsld_pkg::ST_ERROR, tsld_pkg::ERR_BAD_ESC, 1'b0);
                end
                PM_TRIM:
                begin
                    if (c != CH_SP && c != CH_TAB && c != CH_LF && c != CH_CR)
                    begin
                        mode    = PM_MULTI;
                        drop_lf = 1'b0;
                        ml_byte(c);
                    end
                end
                default: go_idle();
            endcase
        endfunction

        // decode one accepted in beat and queue the out beats it owes
        function void note_beat(bit [7:0] b, bit eoi);
            step_q.delete();
            if (eoi)
                end_mark();
            else
                text_byte(b);
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].last = 1'b1;
            foreach (step_q[i])
                decoded_q.push_back(step_q[i]);
            n_beats++;
        endfunction

        task check_beat(result_t got);
            result_t want;
            if (decoded_q.size() == 0)
            begin
                report($sformatf("unexpected beat: byte %02h status %0d err %0d",
                                 got.data, got.status, got.err));
                return;
            end
            want = decoded_q.pop_front();
            if (got.data !== want.data)
                report($sformatf("out_byte %02h, want %02h", got.data, want.data));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.err !== want.err)
                report($sformatf("error_code %0d, want %0d", got.err, want.err));
            if (got.kind !== want.kind)
                report($sformatf("string_kind %0d, want %0d", got.kind, want.kind));
            if (got.unused !== want.unused)
                report($sformatf("byte_unused %0b, want %0b", got.unused, want.unused));
            if (got.last !== want.last)
                report($sformatf("last %0b, want %0b", got.last, want.last));
            case (want.status)
                tsld_pkg::ST_DATA: n_data++;
                tsld_pkg::ST_DONE: n_done++;
                default:           n_err++;
            endcase
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports; every input known from time zero
    // ------------------------------------------------------------------------
    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte      = 8'h00;
    logic       end_of_input = 1'b0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic [2:0] error_code;
    logic [1:0] string_kind;
    logic       byte_unused;
    logic       last;

    decode_scoreboard sb;
    stim_t            stim_q[$];
    int               send_pct = 28;   // chance per beat that the sender idles
    int               recv_pct = 46;   // chance per cycle that the receiver stalls
    int unsigned      cycles   = 0;

    always #(CLK_HALF) clk = ~clk;

    toml_string_literal_decoder dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .status       (status),
        .error_code   (error_code),
        .string_kind  (string_kind),
        .byte_unused  (byte_unused),
        .last         (last)
    );

    // ------------------------------------------------------------------------
    // token stream builder
    // ------------------------------------------------------------------------
    function automatic void add_byte(bit [7:0] b);
        stim_t s;
        s.b   = b;
        s.eoi = 1'b0;
        stim_q.push_back(s);
    endfunction

    // end mark carries a random byte, which the block must ignore
    function automatic void add_eoi();
        stim_t s;
        s.b   = 8'($urandom_range(255));
        s.eoi = 1'b1;
        stim_q.push_back(s);
    endfunction

    function automatic bit [7:0] hex_char(bit [3:0] nib);
        bit upper;
        upper = 1'($urandom_range(1));
        if (nib < 10)
            return 8'h30 + 8'(nib);
        return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
    endfunction

    function automatic bit [7:0] non_hex();
        case ($urandom_range(5))
            0:       return "g";
            1:       return "x";
            2:       return "G";
            3:       return CH_SP;
            4:       return "/";
            default: return "@";
        endcase
    endfunction

    // ndig hex digits of cp, most significant first; digit bad_at is spoiled
    function automatic void add_hex(bit [31:0] cp, int ndig, int bad_at);
        for (int i = ndig - 1; i >= 0; i--)
        begin
            if (i == bad_at)
                add_byte(non_hex());
            else
                add_byte(hex_char(cp[4*i +: 4]));
        end
    endfunction

    function automatic void add_newline();
        case ($urandom_range(2))
            0: add_byte(CH_LF);
            1: add_byte(CH_CR);
            default:
            begin
                add_byte(CH_CR);
                add_byte(CH_LF);
            end
        endcase
    endfunction

    function automatic void add_simple_escape();
        add_byte(CH_BSL);
        case ($urandom_range(6))
            0:       add_byte("b");
            1:       add_byte("t");
            2:       add_byte("n");
            3:       add_byte("f");
            4:       add_byte("r");
            5:       add_byte(CH_DQ);
            default: add_byte(CH_BSL);
        endcase
    endfunction

    // well-formed hex escape spread over the utf-8 length classes
    function automatic void add_hex_escape();
        bit [31:0] cp;
        add_byte(CH_BSL);
        case ($urandom_range(4))
            0:
            begin
                add_byte("u");
                add_hex($urandom_range(32'h7F), 4, -1);
            end
            1:
            begin
                add_byte("u");
                add_hex($urandom_range(32'h80, 32'h7FF), 4, -1);
            end
            2:
            begin
                cp = $urandom_range(32'h800, 32'hFFFF);
                if (cp >= 32'hD800 && cp <= 32'hDFFF)
                    cp = cp ^ 32'h8000;
                add_byte("u");
                add_hex(cp, 4, -1);
            end
            3:
            begin
                add_byte("U");
                add_hex($urandom_range(32'h10000, 32'h10FFFF), 8, -1);
            end
            default:
            begin
                cp = $urandom_range(32'hD7FF);
                add_byte("U");
                add_hex(cp, 8, -1);
            end
        endcase
    endfunction

    // backslash, blanks, newline, then blanks and newlines to be trimmed
    function automatic void add_continuation();
        add_byte(CH_BSL);
        repeat ($urandom_range(2)) add_byte($urandom_range(1) ? CH_SP : CH_TAB);
        add_newline();
        repeat ($urandom_range(3))
        begin
            case ($urandom_range(3))
                0:       add_byte(CH_SP);
                1:       add_byte(CH_TAB);
                2:       add_byte(CH_LF);
                default: add_byte(CH_CR);
            endcase
        end
    endfunction

    // ordinary content: printable, tab or a high byte
    function automatic void add_plain(bit [7:0] q, bit basic);
        bit [7:0] c;
        do
        begin
            case ($urandom_range(9))
                0:       c = CH_TAB;
                1, 2:    c = 8'($urandom_range(8'h80, 8'hFF));
                default: c = 8'($urandom_range(8'h20, 8'h7E));
            endcase
        end
        while (c == q || (basic && c == CH_BSL));
        add_byte(c);
    endfunction

    // byte after a closing quote run; the block reports it as unused unless it is the quote character
    function automatic void add_follow();
        case ($urandom_range(4))
            0:       add_byte(CH_LF);
            1:       add_byte(",");
            2:       add_byte(CH_SP);
            3:       add_byte("#");
            default: add_byte(8'($urandom_range(255)));
        endcase
    endfunction

    // one malformed piece that ends the string with an error
    function automatic void add_fault(bit [1:0] k);
        int       sel;
        bit [7:0] c;
        bit       ml;
        bit       basic;
        ml    = k[1];
        basic = !k[0];
        do sel = $urandom_range(7);
        while ((!basic && sel >= 2 && sel <= 5) || (!ml && sel == 6) ||
               (k != tsld_pkg::KIND_ML_BASIC && sel == 7));
        case (sel)
            0:
            begin
                // control char; cr and lf are newlines in the multiline forms
                do c = ($urandom_range(7) == 0) ? 8'h7F : 8'($urandom_range(31));
                while (c == CH_TAB || (ml && (c == CH_LF || c == CH_CR)));
                add_byte(c);
            end
            1: add_eoi();
            2:
            begin
                add_byte(CH_BSL);
                case ($urandom_range(k == tsld_pkg::KIND_BASIC ? 5 : 4))
                    0:       add_byte("x");
                    1:       add_byte("a");
                    2:       add_byte("0");
                    3:       add_byte("e");
                    4:       add_byte("/");
                    default: add_byte(CH_SP);
                endcase
            end
            3:
            begin
                add_byte(CH_BSL);
                if ($urandom_range(1))
                begin
                    add_byte("u");
                    add_hex($urandom, 4, $urandom_range(3));
                end
                else
                begin
                    add_byte("U");
                    add_hex($urandom, 8, $urandom_range(7));
                end
            end
            4:
            begin
                // surrogate or beyond the unicode range
                add_byte(CH_BSL);
                if ($urandom_range(1))
                begin
                    add_byte("u");
                    add_hex($urandom_range(32'hD800, 32'hDFFF), 4, -1);
                end
                else
                begin
                    add_byte("U");
                    add_hex($urandom_range(32'h110000, 32'hFFFFFFFF), 8, -1);
                end
            end
            5:
            begin
                // text ends inside an escape
                add_byte(CH_BSL);
                if ($urandom_range(1))
                begin
                    add_byte("u");
                    repeat ($urandom_range(3)) add_byte(hex_char(4'($urandom)));
                end
                add_eoi();
            end
            6: repeat (6) add_byte(basic ? CH_DQ : CH_SQ);
            default:
            begin
                // backslash and blanks with no newline after them
                add_byte(CH_BSL);
                repeat ($urandom_range(1, 2)) add_byte($urandom_range(1) ? CH_SP : CH_TAB);
                add_byte("z");
            end
        endcase
    endfunction

    // one string token of random form and content
    function automatic void add_string();
        bit [1:0] k;
        bit [7:0] q;
        bit       ml;
        bit       basic;
        bit       prev_q;
        int       sel;
        k      = 2'($urandom_range(3));
        ml     = k[1];
        basic  = !k[0];
        q      = basic ? CH_DQ : CH_SQ;
        prev_q = 1'b0;
        repeat (ml ? 3 : 1) add_byte(q);
        // newline right after the opening delimiter is dropped
        if (ml && $urandom_range(2) == 0)
            add_newline();
        repeat ($urandom_range(6))
        begin
            sel = $urandom_range(99);
            if (ml && sel < 15 && !prev_q)
            begin
                // content quote run of one or two
                repeat ($urandom_range(1, 2)) add_byte(q);
                prev_q = 1'b1;
            end
            else
            begin
                prev_q = 1'b0;
                if (ml && sel < 30)
                    add_newline();
                else if (basic && sel < 45)
                    add_simple_escape();
                else if (basic && sel < 60)
                    add_hex_escape();
                else if (k == tsld_pkg::KIND_ML_BASIC && sel < 68)
                    add_continuation();
                else
                    add_plain(q, basic);
            end
        end
        sel = $urandom_range(99);
        if (sel < 14)
        begin
            add_fault(k);
        end
        else if (sel < 22)
        begin
            add_eoi();
        end
        else if (!ml)
        begin
            add_byte(q);
        end
        else
        begin
            if (prev_q)
                add_plain(q, basic);
            // closing run of three, sometimes four or five
            repeat ($urandom_range(3) == 0 ? $urandom_range(4, 5) : 3) add_byte(q);
            if ($urandom_range(5) == 0)
                add_eoi();
            else
                add_follow();
        end
    endfunction

    function automatic void add_token();
        int       sel;
        bit [7:0] q;
        sel = $urandom_range(99);
        if (sel < 8)
        begin
            // stray bytes while idle
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(255)));
        end
        else if (sel < 11)
        begin
            add_eoi();
        end
        else if (sel < 19)
        begin
            // empty single-line string, closed by the next byte or the end mark unless that byte is a third quote
            q = $urandom_range(1) ? CH_DQ : CH_SQ;
            add_byte(q);
            add_byte(q);
            if ($urandom_range(3) == 0)
                add_eoi();
            else
                add_follow();
        end
        else
        begin
            add_string();
        end
    endfunction

    // ------------------------------------------------------------------------
    // drivers and monitor
    // ------------------------------------------------------------------------
    // random idle cycles, then hold the beat until the block takes it
    task automatic send_beat(stim_t s);
        while ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_byte      <= s.b;
        end_of_input <= s.eoi;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // receiver backpressure
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_pct);

    // both handshakes sampled at the edge, before any driver update lands
    always @(posedge clk)
    begin : watch
        result_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_beat(in_byte, end_of_input);
            if (out_valid && !out_stall)
            begin
                got.data   = out_byte;
                got.status = status;
                got.err    = error_code;
                got.kind   = string_kind;
                got.unused = byte_unused;
                got.last   = last;
                sb.check_beat(got);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still owed", cycles, sb.pending());
            $display("toml_string_literal_decoder regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int directed_n;
        int total;
        sb = new();

        // directed: end mark and a byte while idle, empty string closed by 0xff,
        // multiline literal with a five-quote close, largest \U escape
        add_eoi();
        add_byte(8'h00);
        add_byte(CH_DQ);
        add_byte(CH_DQ);
        add_byte(8'hFF);
        repeat (3) add_byte(CH_SQ);
        repeat (5) add_byte(CH_SQ);
        add_byte(",");
        add_byte(CH_DQ);
        add_byte(CH_BSL);
        add_byte("U");
        add_hex(32'h10FFFF, 8, -1);
        add_byte(CH_DQ);
        directed_n = stim_q.size();

        while (stim_q.size() - directed_n < RAND_ITEMS)
            add_token();
        total = stim_q.size();

        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // three pacing phases: receiver-heavy stalling, sender-heavy idling, none
        for (int i = 0; i < total; i++)
        begin
            if (i == total / 3)
            begin
                send_pct = 46;
                recv_pct = 28;
            end
            if (i == 2 * total / 3)
            begin
                send_pct = 0;
                recv_pct = 0;
            end
            send_beat(stim_q[i]);
        end
        in_valid <= 1'b0;
        @(posedge clk);

        // drain, then give the queue time to show any stray beat
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected beats never came", sb.pending()));

        $display("%0d in beats (%0d directed) gave %0d data bytes, %0d finished strings"
                 , sb.n_beats, directed_n, sb.n_data, sb.n_done);
        $display("%0d error results, %0d mismatches", sb.n_err, sb.mismatches);
        if (sb.mismatches == 0)
            $display("toml_string_literal_decoder regression: pass");
        else
            $display("toml_string_literal_decoder regression: fail");
        $finish;
    end

endmodule
